>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker of the arena allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define NFA_CHECK_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocator check failed");

// next-cycle implication, sampled on clock, off during reset
`define NFA_CHECK_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

>>> design/nfa_pkg.sv
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared constants and types of the next-fit arena allocator.
// ----------------------------------------------------------------------------
package nfa_pkg;

   localparam int DEFAULT_ARENA_WORDS = 1024;
   localparam int DEFAULT_WORD_BYTES  = 4;

   localparam int SIZE_W      = 16;
   localparam int ADDR_W      = 10;
   localparam int NEED_W      = 17;
   localparam int RECIP_SHIFT = 20;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 16;

   localparam logic KIND_FREE   = 1'b1;
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FREE,
      ST_NEED,
      ST_HDR,
      ST_MERGE,
      ST_TAKE,
      ST_RESP
   } state_type;

endpackage

>>> design/nfa_link_ram.sv
// ----------------------------------------------------------------------------
// nfa_link_ram
// Header link memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nfa_link_ram #(
   parameter int ARENA_WORDS = nfa_pkg::DEFAULT_ARENA_WORDS,
   parameter int AW          = $clog2(ARENA_WORDS)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [AW:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [AW:0]   rd_data
);
   import nfa_pkg::*;

   logic [AW:0] link_mem_ff [ARENA_WORDS];
   logic [AW:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= link_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/nfa_size_conv.sv
// ----------------------------------------------------------------------------
// nfa_size_conv
// Byte count to block words (data words rounded up plus one header word).
// Division by the word size is a reciprocal multiply, two register stages.
// ----------------------------------------------------------------------------
module nfa_size_conv #(
   parameter int WORD_BYTES = nfa_pkg::DEFAULT_WORD_BYTES
) (
   input  logic                      clock,
   input  logic                      load,
   input  logic [nfa_pkg::SIZE_W-1:0] size_bytes,
   output logic [nfa_pkg::NEED_W-1:0] need
);
   import nfa_pkg::*;

   localparam int RECIP_MUL = (2 ** RECIP_SHIFT + WORD_BYTES - 1) / WORD_BYTES;
   localparam int MUL_W     = RECIP_SHIFT + 1;
   localparam int PROD_W    = NEED_W + MUL_W;

   logic [NEED_W-1:0] sum_ff, sum_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [PROD_W-1:0] prod;

   always_comb begin
      sum_in  = NEED_W'(size_bytes) + NEED_W'(2 * WORD_BYTES - 1);
      prod    = PROD_W'(sum_ff) * PROD_W'(MUL_W'(RECIP_MUL));
      need_in = prod[RECIP_SHIFT +: NEED_W];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
      end
      need_ff <= need_in;
   end

   assign need = need_ff;

endmodule

>>> design/nfa_ctrl.sv
// ----------------------------------------------------------------------------
// nfa_ctrl
// Request sequencer: clearing sweep, free, header walk with merging, split,
// and the result register.
// ----------------------------------------------------------------------------
module nfa_ctrl #(
   parameter int ARENA_WORDS = nfa_pkg::DEFAULT_ARENA_WORDS,
   parameter int AW          = $clog2(ARENA_WORDS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic                       req_kind,
   input  logic [nfa_pkg::ADDR_W-1:0] req_addr,
   input  logic [nfa_pkg::NEED_W-1:0] need,
   output logic                       size_load,
   output logic                       wr_en,
   output logic [AW-1:0]              wr_addr,
   output logic [AW:0]                wr_data,
   output logic [AW-1:0]              rd_addr,
   input  logic [AW:0]                rd_data,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [nfa_pkg::ADDR_W-1:0] rsp_addr,
   output logic                       rsp_status
);
   import nfa_pkg::*;

   localparam int SUM_W = ((AW > NEED_W) ? AW : NEED_W) + 1;
   localparam int PW    = ((AW + 1) > ADDR_W) ? (AW + 1) : ADDR_W;
   localparam logic [AW-1:0]    TOP     = AW'(ARENA_WORDS - 1);
   localparam logic [SUM_W-1:0] ARENA_S = SUM_W'(ARENA_WORDS);

   state_type state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [AW-1:0]     p_ff, p_in;
   logic [AW-1:0]     q_ff, q_in;
   logic [AW-1:0]     sp_ff, sp_in;
   logic              laps_ff, laps_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic              res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic              rsp_status_ff, rsp_status_in;

   logic              rd_busy;
   logic [AW-1:0]     rd_next;
   logic [AW-1:0]     eval_q;
   logic [SUM_W-1:0]  rest_s;
   logic [AW-1:0]     rest;
   logic              fits;
   logic              adv_fwd;
   logic              adv_wrap;
   logic              merge_go;
   logic [PW-1:0]     data_word;
   logic              free_ok;

   function automatic logic [SUM_W-1:0] ext(input logic [AW-1:0] v);
      return SUM_W'(v);
   endfunction

   function automatic logic [AW:0] reset_entry(input logic [AW-1:0] i);
      logic [AW:0] e;
      e = '0;
      if (i == '0) begin
         e = {1'b1, AW'(1)};
      end else if (i == AW'(1)) begin
         e = {1'b0, TOP};
      end else if (i == TOP) begin
         e = {1'b1, AW'(0)};
      end
      return e;
   endfunction

   always_comb begin
      rd_busy   = rd_data[AW];
      rd_next   = rd_data[AW-1:0];
      eval_q    = (state_ff == ST_MERGE) ? q_ff : rd_next;
      rest_s    = ext(p_ff) + SUM_W'(need);
      rest      = rest_s[AW-1:0];
      fits      = (eval_q > p_ff) && (ext(eval_q) < ARENA_S) && (ext(eval_q) >= rest_s);
      adv_fwd   = (ext(eval_q) < ARENA_S) && (eval_q > p_ff);
      adv_wrap  = (ext(eval_q) < ARENA_S) && (p_ff == TOP) && (eval_q == '0) && !laps_ff;
      merge_go  = !rd_busy && (rd_next > q_ff) && (ext(rd_next) < ARENA_S);
      data_word = PW'(p_ff) + PW'(1);
      free_ok   = (req_addr != '0) && (SUM_W'(req_addr) < ARENA_S);
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      sp_in         = sp_ff;
      laps_in       = laps_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      req_tready    = 1'b0;
      size_load     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = p_ff;
      wr_data       = '0;
      rd_addr       = p_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = reset_entry(clr_ff);
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == TOP) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_kind == KIND_FREE) begin
                  res_addr_in   = '0;
                  res_status_in = STATUS_DONE;
                  if (free_ok) begin
                     p_in     = AW'(req_addr - ADDR_W'(1));
                     rd_addr  = AW'(req_addr - ADDR_W'(1));
                     state_in = ST_FREE;
                  end else begin
                     state_in = ST_RESP;
                  end
               end else begin
                  size_load = 1'b1;
                  state_in  = ST_NEED;
               end
            end
         end
         ST_FREE: begin
            wr_en    = 1'b1;
            wr_addr  = p_ff;
            wr_data  = {1'b0, rd_next};
            sp_in    = p_ff;
            state_in = ST_RESP;
         end
         ST_NEED: begin
            rd_addr  = sp_ff;
            p_in     = sp_ff;
            laps_in  = 1'b0;
            state_in = ST_HDR;
         end
         ST_HDR, ST_MERGE: begin
            if (state_ff == ST_HDR && !rd_busy && (rd_next > p_ff) &&
                (ext(rd_next) < ARENA_S)) begin
               q_in     = rd_next;
               rd_addr  = rd_next;
               state_in = ST_MERGE;
            end else if (state_ff == ST_MERGE && merge_go) begin
               // absorb the free neighbor, then look at the one after it
               wr_en   = 1'b1;
               wr_addr = p_ff;
               wr_data = {1'b0, rd_next};
               q_in    = rd_next;
               rd_addr = rd_next;
            end else if (state_ff == ST_MERGE && fits) begin
               if (eval_q > rest) begin
                  wr_en   = 1'b1;
                  wr_addr = rest;
                  wr_data = {1'b0, eval_q};
               end
               sp_in         = rest;
               res_addr_in   = data_word[ADDR_W-1:0];
               res_status_in = STATUS_DONE;
               state_in      = ST_TAKE;
            end else if (adv_fwd || adv_wrap) begin
               p_in     = eval_q;
               rd_addr  = eval_q;
               laps_in  = laps_ff | adv_wrap;
               state_in = ST_HDR;
            end else begin
               res_addr_in   = '0;
               res_status_in = STATUS_FAIL;
               state_in      = ST_RESP;
            end
         end
         ST_TAKE: begin
            wr_en    = 1'b1;
            wr_addr  = p_ff;
            wr_data  = {1'b1, sp_ff};
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         sp_ff        <= '0;
         laps_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         laps_ff      <= laps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff          <= p_in;
      q_ff          <= q_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_addr   = rsp_addr_ff;
   assign rsp_status = rsp_status_ff;

endmodule

>>> design/next_fit_arena_allocator_top.sv
// ----------------------------------------------------------------------------
// next_fit_arena_allocator_top
// Next-fit allocator over a word arena with a header link memory.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every arena word that lays
// out the initial header chain; no request is taken during it. Requests are
// handled one at a time. A free reads the block's header and writes it back
// as free before its result is posted; an ignored free goes straight to its
// result. An allocate reads the header at the search pointer, visits headers
// in turn, reads the header after each free one with a forward link and
// merges the free neighbors found on the way: each step costs one access of
// the single-read-port link memory, and a taken block adds a header write.
// The result sits in an output register, so a new request is taken while it
// waits; the next result then holds the sequencer until it leaves.
module next_fit_arena_allocator_top #(
   parameter int ARENA_WORDS = nfa_pkg::DEFAULT_ARENA_WORDS,
   parameter int WORD_BYTES  = nfa_pkg::DEFAULT_WORD_BYTES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [nfa_pkg::REQ_DATA_W-1:0] req_tdata,  // size_bytes[15:0], block_address[25:16]
   input  logic                           req_tuser,  // kind[0]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [nfa_pkg::RSP_DATA_W-1:0] rsp_tdata,  // data_address[9:0]
   output logic                           rsp_tuser   // status[0]
);
   import nfa_pkg::*;

   localparam int AW = $clog2(ARENA_WORDS);

   logic [NEED_W-1:0] need;
   logic              size_load;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [AW:0]       wr_data;
   logic [AW-1:0]     rd_addr;
   logic [AW:0]       rd_data;
   logic [ADDR_W-1:0] rsp_addr;

   nfa_size_conv #(
      .WORD_BYTES (WORD_BYTES)
   ) u_size (
      .clock      (clock),
      .load       (size_load),
      .size_bytes (req_tdata[SIZE_W-1:0]),
      .need       (need)
   );

   nfa_link_ram #(
      .ARENA_WORDS (ARENA_WORDS),
      .AW          (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nfa_ctrl #(
      .ARENA_WORDS (ARENA_WORDS),
      .AW          (AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_addr   (req_tdata[SIZE_W +: ADDR_W]),
      .need       (need),
      .size_load  (size_load),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_addr   (rsp_addr),
      .rsp_status (rsp_tuser)
   );

   assign rsp_tdata = {{(RSP_DATA_W - ADDR_W){1'b0}}, rsp_addr};

endmodule

>>> design/nfa_checker.sv
// ----------------------------------------------------------------------------
// nfa_checker
// Port-level checks of the arena allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nfa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [nfa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);
   import nfa_pkg::*;

   // one request in flight
   `NFA_CHECK_NXT(a_one_in_flight, req_tvalid && req_tready, !req_tready)

   // a stalled result holds
   `NFA_CHECK_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // failed allocation reports address zero
   `NFA_CHECK_IMP(a_fail_zero, rsp_tvalid && rsp_tuser == STATUS_FAIL, rsp_tdata == '0)

   // a result is posted only while no request is taken
   `NFA_CHECK_IMP(a_post_busy, $rose(rsp_tvalid), !$past(req_tready))

endmodule

bind next_fit_arena_allocator_top nfa_checker u_nfa_checker (.*);
